// ===== rtl/bbd_pkg.sv =====
// shared types and constants of the bggr bilinear demosaic core
`default_nettype none
package bbd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int PIX_BITS    = 8;
  localparam int DSHIFT      = SAMPLE_BITS - PIX_BITS;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int MEAN_BITS   = SUM_BITS - DSHIFT;
  localparam int CNT_BITS    = 3;

  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 13;
  localparam int CFG_BITS     = 13;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MIN_WIDTH     = 4;
  localparam int MIN_HEIGHT    = 2;
  localparam int MAX_HEIGHT    = 4096;

  localparam int QUEUE_DEPTH = 8;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   drain;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                frame_end;
  } out_item_t;

  // where the pixel that an item completes sits in the frame
  typedef struct packed {
    logic has_out;
    logic top_edge;
    logic bot_edge;
    logic left_edge;
    logic right_edge;
    logic row_odd;
    logic col_odd;
    logic last;
  } pos_t;

  typedef struct packed {
    logic push;
    logic retire;
  } stage_status_t;

endpackage
`default_nettype wire

// ===== rtl/bayer_bg_bilinear_demosaic_core.sv =====
// bggr bayer to rgb bilinear demosaic, one raw sample in per cycle while in_stall is low
//
// raw samples enter in raster order on in_valid/in_stall/in_data; an item is
// transferred when in_valid is high and in_stall low. each pixel comes out on
// out_valid/out_stall/out_data once the item image_width+1 positions later has
// been taken, so after a frame the source sends image_width+1 drain items.
// the pixel then passes through these steps: line memory read at the
// transfer, then window update, neighbor sums, and mean with queue write.
// throughput is one item per cycle while in_stall is low, set by the single read/write port
// pair of the two row memories, which are read and written back at the same column.
// sizes are written on cfg_we/cfg_index/cfg_wdata while the block is idle.
// reset clears the position counters and loads 640 x 480; the row memories
// need no clearing pass, entries not yet written only feed discarded pixels.
// an 8-entry result queue absorbs receiver stalls; in_stall rises once 8
// items are in flight or waiting, and drops as soon as one leaves.
`default_nettype none
module bayer_bg_bilinear_demosaic_core #(
  parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [bbd_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire bbd_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bbd_pkg::out_item_t                      out_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = CW + 1;
  localparam int HB = bbd_pkg::HEIGHT_BITS;
  localparam int SB = bbd_pkg::SAMPLE_BITS;
  localparam int QD = bbd_pkg::QUEUE_DEPTH;
  localparam int QB = $clog2(QD + 1);

  logic [bbd_pkg::WIDTH_BITS-1:0] cfg_width_r;
  logic [HB-1:0]                  cfg_height_r;

  logic [WB-1:0] weff, w_m1, col_p1, ocol;
  logic [HB-1:0] heff, h_m1, h_p1, orow;

  logic [CW-1:0] col_r, col_nxt;
  logic [HB-1:0] row_r, row_nxt;

  logic          accept;
  logic          pop;
  logic          row_ok, col_ok;
  bbd_pkg::pos_t pos_nxt;

  logic          s1_valid_r;
  logic [SB-1:0] s1_sample_r;
  logic [CW-1:0] s1_addr_r;
  bbd_pkg::pos_t s1_pos_r;

  logic [SB-1:0] up, mid;

  bbd_pkg::stage_status_t status;
  bbd_pkg::out_item_t     pix;

  logic [QB-1:0] cnt_r, cnt_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= bbd_pkg::WIDTH_RESET;
      cfg_height_r <= bbd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bbd_pkg::REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[bbd_pkg::WIDTH_BITS-1:0];
        bbd_pkg::REG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[HB-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: clamped, even
  always_comb begin
    if (int'(cfg_width_r) < bbd_pkg::MIN_WIDTH) begin
      weff = WB'(bbd_pkg::MIN_WIDTH);
    end else if (int'(cfg_width_r) > MAX_WIDTH) begin
      weff = WB'(MAX_WIDTH);
    end else begin
      weff = WB'(cfg_width_r);
    end
    weff[0] = 1'b0;

    if (int'(cfg_height_r) < bbd_pkg::MIN_HEIGHT) begin
      heff = HB'(bbd_pkg::MIN_HEIGHT);
    end else if (int'(cfg_height_r) > bbd_pkg::MAX_HEIGHT) begin
      heff = HB'(bbd_pkg::MAX_HEIGHT);
    end else begin
      heff = cfg_height_r;
    end
    heff[0] = 1'b0;

    w_m1 = weff - WB'(1);
    h_m1 = heff - HB'(1);
    h_p1 = heff + HB'(1);
  end

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  // position of the pixel completed by the incoming item
  always_comb begin
    col_p1 = {1'b0, col_r} + WB'(1);
    if (col_r != '0) begin
      orow   = row_r - HB'(1);
      ocol   = {1'b0, col_r} - WB'(1);
      row_ok = (row_r != '0) && (row_r <= heff);
      col_ok = ({1'b0, col_r} <= weff);
    end else begin
      orow   = row_r - HB'(2);
      ocol   = w_m1;
      row_ok = (row_r >= HB'(2)) && (row_r <= h_p1);
      col_ok = 1'b1;
    end
    pos_nxt.has_out    = row_ok && col_ok;
    pos_nxt.top_edge   = (orow == '0);
    pos_nxt.bot_edge   = (orow == h_m1);
    pos_nxt.left_edge  = (ocol == '0);
    pos_nxt.right_edge = (ocol == w_m1);
    pos_nxt.row_odd    = orow[0];
    pos_nxt.col_odd    = ocol[0];
    pos_nxt.last       = (orow == h_m1) && (ocol == w_m1);

    if (row_r >= h_p1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_p1 >= weff) begin
      col_nxt = '0;
      row_nxt = row_r + HB'(1);
    end else begin
      col_nxt = col_p1[CW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_data.drain ? '0 : in_data.sample;
      s1_addr_r   <= col_r;
      s1_pos_r    <= pos_nxt;
    end
  end

  bbd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr   (col_r),
    .wr_en     (s1_valid_r),
    .wr_addr   (s1_addr_r),
    .wr_sample (s1_sample_r),
    .up_o      (up),
    .mid_o     (mid)
  );

  bbd_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (s1_valid_r),
    .sample (s1_sample_r),
    .pos    (s1_pos_r),
    .up     (up),
    .mid    (mid),
    .status (status),
    .item   (pix)
  );

  bbd_out_queue #(
    .DEPTH (QD)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (status.push),
    .push_item (pix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // items in flight or queued; bounded by the queue depth
  assign cnt_nxt  = cnt_r + QB'(accept) - QB'(pop) - QB'(status.retire);
  assign in_stall = (cnt_r == QB'(QD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QB'(QD))
    else $error("outstanding item count above queue depth");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    status.push |=> out_valid)
    else $error("pushed pixel not presented");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (row_r >= h_p1)) |=> ((col_r == '0) && (row_r == '0)))
    else $error("counters did not wrap after the last drain item");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("result presented with no outstanding item");

endmodule
`default_nettype wire

// ===== rtl/bbd_line_store.sv =====
// two row memories with read-modify-write and same-entry forwarding
`default_nettype none
module bbd_line_store #(
  parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
  input  wire logic [bbd_pkg::SAMPLE_BITS-1:0]  wr_sample,
  output logic      [bbd_pkg::SAMPLE_BITS-1:0]  up_o,
  output logic      [bbd_pkg::SAMPLE_BITS-1:0]  mid_o
);

  localparam int SB = bbd_pkg::SAMPLE_BITS;

  logic [SB-1:0] upper_mem [MAX_WIDTH];
  logic [SB-1:0] middle_mem [MAX_WIDTH];
  logic [SB-1:0] up_q_r;
  logic [SB-1:0] mid_q_r;
  logic [SB-1:0] lw_up_r;
  logic [SB-1:0] lw_mid_r;
  logic          hit_r;
  logic          hit_nxt;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q_r  <= upper_mem[rd_addr];
      mid_q_r <= middle_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_o;
      middle_mem[wr_addr] <= wr_sample;
    end
  end

  // read and write of one entry in the same cycle: the read sees old data
  assign hit_nxt = rd_en && wr_en && (rd_addr == wr_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_up_r  <= mid_o;
      lw_mid_r <= wr_sample;
    end
  end

  assign up_o  = hit_r ? lw_up_r  : up_q_r;
  assign mid_o = hit_r ? lw_mid_r : mid_q_r;

endmodule
`default_nettype wire

// ===== rtl/bbd_interp.sv =====
// 3x3 window, neighbor sums and per-channel mean
`default_nettype none
module bbd_interp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            valid,
  input  wire logic [bbd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire bbd_pkg::pos_t                   pos,
  input  wire logic [bbd_pkg::SAMPLE_BITS-1:0] up,
  input  wire logic [bbd_pkg::SAMPLE_BITS-1:0] mid,
  output bbd_pkg::stage_status_t               status,
  output bbd_pkg::out_item_t                   item
);

  localparam int SB  = bbd_pkg::SAMPLE_BITS;
  localparam int SW  = bbd_pkg::SUM_BITS;
  localparam int CB  = bbd_pkg::CNT_BITS;
  localparam int PB  = bbd_pkg::PIX_BITS;
  localparam int MB  = bbd_pkg::MEAN_BITS;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_BITS  = MB + 10;

  localparam logic [1:0] SITE_BLUE    = 2'b00;
  localparam logic [1:0] SITE_GREEN_B = 2'b01;
  localparam logic [1:0] SITE_GREEN_R = 2'b10;
  localparam logic [1:0] SITE_RED     = 2'b11;

  function automatic logic [SW-1:0] pick(input logic [SB-1:0] v, input logic en);
    return en ? SW'(v) : '0;
  endfunction

  // truncated sum / (n << DSHIFT); n of three by reciprocal multiply
  function automatic logic [PB-1:0] mean_of(input logic [SW-1:0] sum, input logic [CB-1:0] n);
    logic [MB-1:0]        x;
    logic [PROD_BITS-1:0] p;
    logic [PB-1:0]        m;
    x = MB'(sum >> bbd_pkg::DSHIFT);
    p = PROD_BITS'(x) * PROD_BITS'(DIV3_MUL);
    case (n)
      3'd1:    m = x[PB-1:0];
      3'd2:    m = x[PB:1];
      3'd3:    m = p[DIV3_SHIFT+PB-1:DIV3_SHIFT];
      3'd4:    m = x[PB+1:2];
      default: m = '0;
    endcase
    return m;
  endfunction

  logic [SB-1:0] win_r [3][3];

  logic          s2_valid_r;
  bbd_pkg::pos_t s2_pos_r;

  logic          s3_valid_r;
  logic          s3_has_out_r;
  logic          s3_last_r;
  logic [SW-1:0] s3_r_sum_r, s3_g_sum_r, s3_b_sum_r;
  logic [CB-1:0] s3_r_cnt_r, s3_g_cnt_r, s3_b_cnt_r;

  logic          en_u, en_d, en_l, en_r;
  logic [SW-1:0] hs, vs, ds, es, cs;
  logic [CB-1:0] hn, vn, dn, en;
  logic [SW-1:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;
  logic [CB-1:0] r_cnt_nxt, g_cnt_nxt, b_cnt_nxt;

  always_ff @(posedge clk) begin
    if (valid) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= up;
      win_r[1][2] <= mid;
      win_r[2][2] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid) begin
      s2_pos_r <= pos;
    end
  end

  always_comb begin
    en_u = !s2_pos_r.top_edge;
    en_d = !s2_pos_r.bot_edge;
    en_l = !s2_pos_r.left_edge;
    en_r = !s2_pos_r.right_edge;

    hs = pick(win_r[1][0], en_l) + pick(win_r[1][2], en_r);
    hn = CB'(en_l) + CB'(en_r);
    vs = pick(win_r[0][1], en_u) + pick(win_r[2][1], en_d);
    vn = CB'(en_u) + CB'(en_d);
    ds = pick(win_r[0][0], en_u && en_l) + pick(win_r[0][2], en_u && en_r)
       + pick(win_r[2][0], en_d && en_l) + pick(win_r[2][2], en_d && en_r);
    dn = CB'(en_u && en_l) + CB'(en_u && en_r) + CB'(en_d && en_l) + CB'(en_d && en_r);
    es = hs + vs;
    en = hn + vn;
    // own colour goes through the mean with a count of one
    cs = SW'(win_r[1][1]);

    case ({s2_pos_r.row_odd, s2_pos_r.col_odd})
      SITE_BLUE: begin
        r_sum_nxt = ds; r_cnt_nxt = dn;
        g_sum_nxt = es; g_cnt_nxt = en;
        b_sum_nxt = cs; b_cnt_nxt = CB'(1);
      end
      SITE_GREEN_B: begin
        r_sum_nxt = vs; r_cnt_nxt = vn;
        g_sum_nxt = cs; g_cnt_nxt = CB'(1);
        b_sum_nxt = hs; b_cnt_nxt = hn;
      end
      SITE_GREEN_R: begin
        r_sum_nxt = hs; r_cnt_nxt = hn;
        g_sum_nxt = cs; g_cnt_nxt = CB'(1);
        b_sum_nxt = vs; b_cnt_nxt = vn;
      end
      SITE_RED: begin
        r_sum_nxt = cs; r_cnt_nxt = CB'(1);
        g_sum_nxt = es; g_cnt_nxt = en;
        b_sum_nxt = ds; b_cnt_nxt = dn;
      end
      default: begin
        r_sum_nxt = '0; r_cnt_nxt = '0;
        g_sum_nxt = '0; g_cnt_nxt = '0;
        b_sum_nxt = '0; b_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_has_out_r <= s2_pos_r.has_out;
      s3_last_r    <= s2_pos_r.last;
      s3_r_sum_r   <= r_sum_nxt;
      s3_g_sum_r   <= g_sum_nxt;
      s3_b_sum_r   <= b_sum_nxt;
      s3_r_cnt_r   <= r_cnt_nxt;
      s3_g_cnt_r   <= g_cnt_nxt;
      s3_b_cnt_r   <= b_cnt_nxt;
    end
  end

  always_comb begin
    item.red       = mean_of(s3_r_sum_r, s3_r_cnt_r);
    item.green     = mean_of(s3_g_sum_r, s3_g_cnt_r);
    item.blue      = mean_of(s3_b_sum_r, s3_b_cnt_r);
    item.frame_end = s3_last_r;
    status.push    = s3_valid_r && s3_has_out_r;
    status.retire  = s3_valid_r && !s3_has_out_r;
  end

endmodule
`default_nettype wire

// ===== rtl/bbd_out_queue.sv =====
// result queue between the pixel pipeline and the output channel
`default_nettype none
module bbd_out_queue #(
  parameter int DEPTH = bbd_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bbd_pkg::out_item_t push_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bbd_pkg::out_item_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int NB = $clog2(DEPTH + 1);

  bbd_pkg::out_item_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [NB-1:0] cnt_r;
  logic [NB-1:0] cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign cnt_nxt   = cnt_r + NB'(push) - NB'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== dv/bayer_bg_bilinear_demosaic_core_tb.sv =====
// self-checking testbench of the bggr bilinear demosaic core with its own pixel predictor
module bayer_bg_bilinear_demosaic_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW         = bbd_pkg::MAX_WIDTH_DEF;
  localparam int WIDE_ITEMS   = 200;
  localparam int RANDOM_ITEMS = 1440;
  localparam int CALM_ITEMS   = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT        = 1_000_000;
  localparam int DIR_COUNT    = 26;

  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} color_e;

  typedef struct packed {
    logic [bbd_pkg::SAMPLE_BITS-1:0] sample;
    logic                            drain;
    logic                            typed;
    logic                            has_px;
    bbd_pkg::out_item_t              px;
  } dir_row_t;

  localparam bbd_pkg::out_item_t PX_NONE      = '0;
  localparam bbd_pkg::out_item_t PX_WHITE     = '{8'd255, 8'd255, 8'd255, 1'b0};
  localparam bbd_pkg::out_item_t PX_WHITE_END = '{8'd255, 8'd255, 8'd255, 1'b1};

  // 4 x 2 frame of full-scale samples, then a 4 x 2 frame checked by the predictor
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{12'hFFF, 1'b0, 1'b1, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b1, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b1, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b1, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b1, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b1, 1'b1, PX_WHITE},
    '{12'hFFF, 1'b0, 1'b1, 1'b1, PX_WHITE},
    '{12'hFFF, 1'b0, 1'b1, 1'b1, PX_WHITE},
    '{12'h000, 1'b1, 1'b1, 1'b1, PX_WHITE},
    // plain sample during the drain row, must not leak into the pixels
    '{12'h000, 1'b0, 1'b1, 1'b1, PX_WHITE},
    '{12'hFFF, 1'b1, 1'b1, 1'b1, PX_WHITE},
    '{12'h000, 1'b1, 1'b1, 1'b1, PX_WHITE},
    '{12'h000, 1'b1, 1'b1, 1'b1, PX_WHITE_END},
    '{12'h000, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'h800, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'h7FF, 1'b0, 1'b0, 1'b0, PX_NONE},
    // drain flag inside the frame counts as a zero sample
    '{12'hABC, 1'b1, 1'b0, 1'b0, PX_NONE},
    '{12'h555, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'hAAA, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'h123, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'hFFF, 1'b0, 1'b0, 1'b0, PX_NONE},
    '{12'h3C3, 1'b1, 1'b0, 1'b0, PX_NONE},
    '{12'hFFF, 1'b1, 1'b0, 1'b0, PX_NONE},
    '{12'h000, 1'b1, 1'b0, 1'b0, PX_NONE},
    '{12'hE71, 1'b1, 1'b0, 1'b0, PX_NONE}
  };

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [bbd_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [bbd_pkg::CFG_BITS-1:0]     cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  bbd_pkg::in_item_t                in_data;
  logic                             out_valid;
  logic                             out_stall;
  bbd_pkg::out_item_t               out_data;

  bayer_bg_bilinear_demosaic_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predictor state
  logic [bbd_pkg::WIDTH_BITS-1:0]  width_reg;
  logic [bbd_pkg::HEIGHT_BITS-1:0] height_reg;
  logic [bbd_pkg::SAMPLE_BITS-1:0] older_row_mem [MAXW];
  logic [bbd_pkg::SAMPLE_BITS-1:0] last_row_mem [MAXW];
  logic [bbd_pkg::SAMPLE_BITS-1:0] nbhd [3][3];
  int                              next_col;
  int                              next_row;

  bbd_pkg::out_item_t pending_px [$];
  int                 errors;
  int                 cycles;

  // typed expectation for the directed row on the bus
  bit                 row_typed;
  bit                 row_has;
  bbd_pkg::out_item_t row_px;

  bit calm;
  bit hold_req;
  int hold_left;
  int stall_left;

  function automatic int frame_w();
    int w;
    w = int'(width_reg);
    if (w < bbd_pkg::MIN_WIDTH) w = bbd_pkg::MIN_WIDTH;
    if (w > MAXW) w = MAXW;
    return w & ~1;
  endfunction

  function automatic int frame_h();
    int h;
    h = int'(height_reg);
    if (h < bbd_pkg::MIN_HEIGHT) h = bbd_pkg::MIN_HEIGHT;
    if (h > bbd_pkg::MAX_HEIGHT) h = bbd_pkg::MAX_HEIGHT;
    return h & ~1;
  endfunction

  function automatic color_e site_color(int y, int x);
    if (!y[0] && !x[0]) return CH_BLUE;
    if (y[0] && x[0]) return CH_RED;
    return CH_GREEN;
  endfunction

  function automatic logic [bbd_pkg::PIX_BITS-1:0] color_at(color_e ch, int r, int c,
                                                            int w, int h);
    int unsigned acc;
    int unsigned cnt;
    int          y;
    int          x;
    if (site_color(r, c) == ch) return bbd_pkg::PIX_BITS'(nbhd[1][1] >> bbd_pkg::DSHIFT);
    acc = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        y = r + dr;
        x = c + dc;
        if ((dr != 0 || dc != 0) && y >= 0 && y < h && x >= 0 && x < w &&
            site_color(y, x) == ch) begin
          acc += nbhd[dr+1][dc+1];
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    return bbd_pkg::PIX_BITS'(acc / (cnt << bbd_pkg::DSHIFT));
  endfunction

  // advances the predictor by one transfer, returns 1 when a pixel is due
  function automatic bit demosaic_pixel(input bbd_pkg::in_item_t it,
                                        output bbd_pkg::out_item_t px);
    int                              w;
    int                              h;
    int                              ci;
    int                              orow;
    int                              ocol;
    logic [bbd_pkg::SAMPLE_BITS-1:0] s;
    logic [bbd_pkg::SAMPLE_BITS-1:0] up;
    logic [bbd_pkg::SAMPLE_BITS-1:0] mid;
    w  = frame_w();
    h  = frame_h();
    s  = it.drain ? '0 : it.sample;
    ci = next_col < MAXW ? next_col : MAXW - 1;
    up  = older_row_mem[ci];
    mid = last_row_mem[ci];
    older_row_mem[ci] = mid;
    last_row_mem[ci]  = s;
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = mid;
    nbhd[2][2] = s;
    // column 0 completes the last pixel of the row before
    if (next_col >= 1) begin
      ocol = next_col - 1;
      orow = next_row - 1;
    end else begin
      ocol = w - 1;
      orow = next_row - 2;
    end
    if (next_row >= h + 1) begin
      next_col = 0;
      next_row = 0;
    end else begin
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
    end
    px = '0;
    if (orow < 0 || orow >= h || ocol < 0 || ocol >= w) return 1'b0;
    px.red       = color_at(CH_RED, orow, ocol, w, h);
    px.green     = color_at(CH_GREEN, orow, ocol, w, h);
    px.blue      = color_at(CH_BLUE, orow, ocol, w, h);
    px.frame_end = (orow == h - 1 && ocol == w - 1);
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout, %0d pixels still expected", $time, pending_px.size());
      $display("FAIL");
      $finish;
    end
  end

  // register writes, input transfers and output transfers as seen at the clock edge
  always @(posedge clk) begin : watch
    bbd_pkg::out_item_t px;
    bbd_pkg::out_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          bbd_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_wdata[bbd_pkg::WIDTH_BITS-1:0];
          end
          bbd_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_wdata[bbd_pkg::HEIGHT_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        if (demosaic_pixel(in_data, px) && !row_typed) pending_px.push_back(px);
        if (row_typed && row_has) pending_px.push_back(row_px);
      end
      if (out_valid && !out_stall) begin
        if (pending_px.size() == 0) begin
          errors++;
          if (errors < 200)
            $display("%0t: unexpected pixel, expected none, got r=%0d g=%0d b=%0d end=%0b",
                     $time, out_data.red, out_data.green, out_data.blue, out_data.frame_end);
        end else begin
          want = pending_px.pop_front();
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue || out_data.frame_end !== want.frame_end) begin
            errors++;
            if (errors < 200)
              $display({"%0t: pixel mismatch, expected r=%0d g=%0d b=%0d end=%0b,",
                        " got r=%0d g=%0d b=%0d end=%0b"},
                       $time, want.red, want.green, want.blue, want.frame_end,
                       out_data.red, out_data.green, out_data.blue, out_data.frame_end);
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_item(input bbd_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (!calm && !hold_req && hold_left == 0 && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // wait until every pixel has come out and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_sizes(input bit do_w, input logic [bbd_pkg::CFG_BITS-1:0] w,
                           input bit do_h, input logic [bbd_pkg::CFG_BITS-1:0] h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= bbd_pkg::REG_IMAGE_WIDTH;
      cfg_wdata <= w;
      @(negedge clk);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= bbd_pkg::REG_IMAGE_HEIGHT;
      cfg_wdata <= h;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic reshape();
    logic [bbd_pkg::CFG_BITS-1:0] w;
    logic [bbd_pkg::CFG_BITS-1:0] h;
    int                           pick;
    if ($urandom_range(0, 3) == 0) begin
      // odd and out-of-range widths, sometimes with a bit above the register
      w = bbd_pkg::CFG_BITS'($urandom_range(0, 17));
      if ($urandom_range(0, 1) == 0) w[bbd_pkg::CFG_BITS-1] = 1'b1;
    end else begin
      w = bbd_pkg::CFG_BITS'(2 * $urandom_range(2, 8));
    end
    if ($urandom_range(0, 3) == 0) h = bbd_pkg::CFG_BITS'($urandom_range(0, 9));
    else h = bbd_pkg::CFG_BITS'(2 * $urandom_range(1, 4));
    pick = $urandom_range(0, 2);
    settle();
    set_sizes(pick != 2, w, pick != 1, h);
  endtask

  // mostly real samples inside the frame and filler after it, with some of each misplaced
  function automatic bbd_pkg::in_item_t pick_item();
    bbd_pkg::in_item_t it;
    it.sample = bbd_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
    if (next_row < frame_h()) it.drain = ($urandom_range(0, 15) == 0);
    else it.drain = ($urandom_range(0, 7) != 0);
    return it;
  endfunction

  initial begin
    int                moved;
    bbd_pkg::in_item_t it;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = bbd_pkg::REG_IMAGE_WIDTH;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    width_reg  = bbd_pkg::WIDTH_RESET;
    height_reg = bbd_pkg::HEIGHT_RESET;
    foreach (older_row_mem[i]) older_row_mem[i] = '0;
    foreach (last_row_mem[i]) last_row_mem[i] = '0;
    foreach (nbhd[r, c]) nbhd[r][c] = '0;
    next_col = 0;
    next_row = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_sizes(1'b1, bbd_pkg::CFG_BITS'(4), 1'b1, bbd_pkg::CFG_BITS'(2));
    for (int i = 0; i < DIR_COUNT; i++) begin
      row_typed  = dir_rows[i].typed;
      row_has    = dir_rows[i].has_px;
      row_px     = dir_rows[i].px;
      it.sample  = dir_rows[i].sample;
      it.drain   = dir_rows[i].drain;
      idle_gap();
      push_item(it);
    end
    row_typed = 1'b0;

    // widest row and tallest frame on part of a row, then shrink in mid frame
    settle();
    set_sizes(1'b1, bbd_pkg::CFG_BITS'(4095), 1'b1, bbd_pkg::CFG_BITS'(13'h1FFF));
    repeat (WIDE_ITEMS) begin
      idle_gap();
      push_item(pick_item());
    end
    settle();
    // a 16-wide frame fills both row memories over every column used later
    set_sizes(1'b1, bbd_pkg::CFG_BITS'(16), 1'b1, bbd_pkg::CFG_BITS'(2));
    while (next_row != 0 || next_col != 0) begin
      idle_gap();
      push_item(pick_item());
    end
    settle();
    set_sizes(1'b1, bbd_pkg::CFG_BITS'(6), 1'b1, bbd_pkg::CFG_BITS'(6));

    moved = 0;
    while (moved < RANDOM_ITEMS || next_row != 0 || next_col != 0) begin
      if (moved >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (moved == 200) hold_req = 1'b1;
      if (!calm && hold_left == 0 && !hold_req) begin
        if (next_row == 0 && next_col == 0) begin
          if ($urandom_range(0, 2) == 0) reshape();
        end else if ($urandom_range(0, 149) == 0) begin
          reshape();
        end
      end
      idle_gap();
      push_item(pick_item());
      moved++;
    end
    in_valid <= 1'b0;

    while (pending_px.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
